[rtl/core/dmc_pkg.sv]
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int MAX_SIDE = 32;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int DEPTH_W  = ADDR_W + 1;
  localparam int SIZE_W   = 6;
  localparam int EPOCH_W  = 8;
  localparam int MAZE_W   = EPOCH_W + 4;
  localparam int FRAME_W  = 2 * COORD_W + 10;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] DIR_E = 2'd0;
  localparam logic [1:0] DIR_W = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_N = 2'd3;

  localparam logic [2:0] EV_ENTRANCE  = 3'd0;
  localparam logic [2:0] EV_CARVE     = 3'd1;
  localparam logic [2:0] EV_BACKTRACK = 3'd2;
  localparam logic [2:0] EV_FINISH    = 3'd3;
  localparam logic [2:0] EV_IGNORED   = 3'd4;

  typedef struct packed {
    logic       op;
    logic [4:0] start_x;
    logic [4:0] start_y;
    logic [1:0] start_dir;
    logic [4:0] order_pick;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [1:0] wall_dir;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [1:0]         from;
    logic [4:0]         pick;
    logic [2:0]         next;
  } frame_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [3:0]         walls;
  } maze_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    maze_entry_t       data;
  } maze_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    frame_t            data;
  } stack_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOP,
    ST_MOD,
    ST_START,
    ST_SCAN,
    ST_NCHK,
    ST_CUR,
    ST_PUSH,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  function automatic logic [3:0] dir_bit(logic [1:0] d);
    return 4'b0001 << d;
  endfunction

  function automatic logic [3:0] neighbor_mask(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                               logic [SIZE_W-1:0] n);
    logic [3:0] m;
    m[DIR_E] = (SIZE_W'(x) + SIZE_W'(2)) <= n;
    m[DIR_W] = (x != '0);
    m[DIR_S] = (SIZE_W'(y) + SIZE_W'(2)) <= n;
    m[DIR_N] = (y != '0);
    return m;
  endfunction

  function automatic logic [2:0] mask_count(logic [3:0] m);
    return 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
  endfunction

  function automatic logic [3:0][1:0] perm_dirs(logic [3:0] avail, logic [4:0] pick);
    logic [1:0]      list [4];
    logic [1:0]      q    [4];
    logic [2:0]      cnt;
    logic [4:0]      r;
    logic [3:0][1:0] res;
    cnt = '0;
    r   = pick;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      list[i] = '0;
      q[i]    = '0;
    end
    for (int d = 0; d < 4; d++) begin
      if (avail[d]) begin
        list[cnt[1:0]] = 2'(d);
        cnt = cnt + 3'd1;
      end
    end
    case (cnt)
      3'd4: begin
        if (r >= 5'd24) r = r - 5'd24;
        if (r >= 5'd18) begin
          q[0] = 2'd3;
          r = r - 5'd18;
        end else if (r >= 5'd12) begin
          q[0] = 2'd2;
          r = r - 5'd12;
        end else if (r >= 5'd6) begin
          q[0] = 2'd1;
          r = r - 5'd6;
        end
        q[1] = (r >= 5'd4) ? 2'd2 : ((r >= 5'd2) ? 2'd1 : 2'd0);
        q[2] = {1'b0, r[0]};
      end
      3'd3: begin
        for (int k = 0; k < 5; k++) begin
          if (r >= 5'd6) r = r - 5'd6;
        end
        q[0] = (r >= 5'd4) ? 2'd2 : ((r >= 5'd2) ? 2'd1 : 2'd0);
        q[1] = {1'b0, r[0]};
      end
      3'd2: begin
        q[0] = {1'b0, r[0]};
      end
      default: ;
    endcase
    for (int k = 0; k < 4; k++) begin
      res[k] = list[q[k]];
      for (int j = 0; j < 3; j++) begin
        if (2'(j) >= q[k]) list[j] = list[j + 1];
      end
    end
    return res;
  endfunction

endpackage

[rtl/core/dfs_maze_carver.sv]
`timescale 1ns / 1ps

// Depth-first maze carver. A start item (op 0) opens the entrance of the start
// cell and pushes it; each step item (op 1) resumes the cell on top of the stack
// and carves into one unvisited neighbor, pops the cell, or, with the stack empty,
// is ignored. Every input item yields exactly one result item on the out_ channel.
// The cfg_ channel writes grid_size at any cycle; cfg_ready is always high.
// Cell state (visited epoch and walls) and the path stack live in two RAMs
// with a registered read, both driven by the controller.
// A carving step runs TOP, SCAN, NCHK, CUR, PUSH and EMIT, with one more SCAN
// for a neighbor skipped as the entry side and one more SCAN and NCHK for each
// visited neighbor. A backtracking step scans the remaining directions and
// pops. A start reduces its coordinates modulo the grid size, then opens and
// pushes the start cell. One item is worked on at a time; in_ready is high
// only between items. After reset the cell RAM is swept with in_ready low;
// the same sweep runs before one start in every 255, when the epoch counter
// wraps. A result waits in the output register while out_ready is low; the
// next item is still accepted and worked on until its own result is due.
module dfs_maze_carver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  dmc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dmc_pkg::out_item_t  out_item
);

  logic [dmc_pkg::SIZE_W-1:0]  grid_size_r;
  logic [dmc_pkg::ADDR_W-1:0]  maze_rd_addr;
  dmc_pkg::maze_entry_t        maze_rd_data;
  dmc_pkg::maze_wr_t           maze_wr;
  logic [dmc_pkg::ADDR_W-1:0]  stack_rd_addr;
  dmc_pkg::frame_t             stack_rd_data;
  dmc_pkg::stack_wr_t          stack_wr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= dmc_pkg::SIZE_W'(dmc_pkg::MAX_SIDE);
    end else if (cfg_valid && cfg_ready) begin
      grid_size_r <= cfg_data;
    end
  end

  dmc_ram #(
    .WIDTH (dmc_pkg::MAZE_W),
    .DEPTH (dmc_pkg::CELLS)
  ) u_maze_ram (
    .clk     (clk),
    .wr_en   (maze_wr.en),
    .wr_addr (maze_wr.addr),
    .wr_data (maze_wr.data),
    .rd_addr (maze_rd_addr),
    .rd_data (maze_rd_data)
  );

  dmc_ram #(
    .WIDTH (dmc_pkg::FRAME_W),
    .DEPTH (dmc_pkg::CELLS)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stack_wr.en),
    .wr_addr (stack_wr.addr),
    .wr_data (stack_wr.data),
    .rd_addr (stack_rd_addr),
    .rd_data (stack_rd_data)
  );

  dmc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .grid_size     (grid_size_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .maze_rd_addr  (maze_rd_addr),
    .maze_rd_data  (maze_rd_data),
    .maze_wr       (maze_wr),
    .stack_rd_addr (stack_rd_addr),
    .stack_rd_data (stack_rd_data),
    .stack_wr      (stack_wr)
  );

endmodule

[rtl/core/dmc_ram.sv]
`timescale 1ns / 1ps

module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/dmc_ctrl.sv]
`timescale 1ns / 1ps

module dmc_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dmc_pkg::SIZE_W-1:0]     grid_size,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dmc_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dmc_pkg::out_item_t             out_item,
  output logic [dmc_pkg::ADDR_W-1:0]     maze_rd_addr,
  input  dmc_pkg::maze_entry_t           maze_rd_data,
  output dmc_pkg::maze_wr_t              maze_wr,
  output logic [dmc_pkg::ADDR_W-1:0]     stack_rd_addr,
  input  dmc_pkg::frame_t                stack_rd_data,
  output dmc_pkg::stack_wr_t             stack_wr
);

  dmc_pkg::state_t                 state_r, state_nxt;
  dmc_pkg::state_t                 clr_ret_r, clr_ret_nxt;
  logic [dmc_pkg::ADDR_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [dmc_pkg::DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [dmc_pkg::EPOCH_W-1:0]     epoch_r, epoch_nxt;
  logic                            out_valid_r, out_valid_nxt;
  dmc_pkg::out_item_t              out_item_r, out_item_nxt;
  dmc_pkg::out_item_t              res_r, res_nxt;
  dmc_pkg::in_item_t               item_r, item_nxt;
  dmc_pkg::frame_t                 frame_r, frame_nxt;
  logic [3:0][1:0]                 dirs_r, dirs_nxt;
  logic [2:0]                      cnt_r, cnt_nxt;
  logic [2:0]                      idx_r, idx_nxt;
  logic [dmc_pkg::COORD_W-1:0]     sx_r, sx_nxt;
  logic [dmc_pkg::COORD_W-1:0]     sy_r, sy_nxt;
  logic [dmc_pkg::COORD_W-1:0]     nx_r, nx_nxt;
  logic [dmc_pkg::COORD_W-1:0]     ny_r, ny_nxt;
  logic [1:0]                      dir_r, dir_nxt;

  logic [dmc_pkg::SIZE_W-1:0]      n_eff;
  logic [3:0]                      avail;
  logic [1:0]                      d_sel;
  logic [dmc_pkg::COORD_W-1:0]     nx_c;
  logic [dmc_pkg::COORD_W-1:0]     ny_c;
  logic                            hit;
  logic [3:0]                      walls_eff;
  logic                            sx_big;
  logic                            sy_big;
  dmc_pkg::frame_t                 push_frame;
  dmc_pkg::frame_t                 top_frame;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    if (grid_size < dmc_pkg::SIZE_W'(2)) begin
      n_eff = dmc_pkg::SIZE_W'(2);
    end else if (grid_size > dmc_pkg::SIZE_W'(dmc_pkg::MAX_SIDE)) begin
      n_eff = dmc_pkg::SIZE_W'(dmc_pkg::MAX_SIDE);
    end else begin
      n_eff = grid_size;
    end
  end

  assign avail     = dmc_pkg::neighbor_mask(stack_rd_data.x, stack_rd_data.y, n_eff);
  assign d_sel     = dirs_r[idx_r[1:0]];
  assign hit       = (maze_rd_data.epoch == epoch_r);
  assign walls_eff = hit ? maze_rd_data.walls : 4'hF;
  assign sx_big    = (dmc_pkg::SIZE_W'(sx_r) >= n_eff);
  assign sy_big    = (dmc_pkg::SIZE_W'(sy_r) >= n_eff);

  always_comb begin
    nx_c = frame_r.x;
    ny_c = frame_r.y;
    case (d_sel)
      dmc_pkg::DIR_E: nx_c = frame_r.x + 1'b1;
      dmc_pkg::DIR_W: nx_c = frame_r.x - 1'b1;
      dmc_pkg::DIR_S: ny_c = frame_r.y + 1'b1;
      dmc_pkg::DIR_N: ny_c = frame_r.y - 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    push_frame.x    = nx_r;
    push_frame.y    = ny_r;
    push_frame.from = dir_r ^ 2'b01;
    push_frame.pick = item_r.order_pick;
    push_frame.next = '0;
    top_frame       = frame_r;
    top_frame.next  = idx_r + 3'd1;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_ret_nxt   = clr_ret_r;
    clr_cnt_nxt   = clr_cnt_r;
    depth_nxt     = depth_r;
    epoch_nxt     = epoch_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_item_nxt  = out_item_r;
    res_nxt       = res_r;
    item_nxt      = item_r;
    frame_nxt     = frame_r;
    dirs_nxt      = dirs_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    dir_nxt       = dir_r;
    in_ready      = 1'b0;
    maze_rd_addr  = {frame_r.y, frame_r.x};
    maze_wr       = '0;
    stack_rd_addr = dmc_pkg::ADDR_W'(depth_r - 1'b1);
    stack_wr      = '0;

    case (state_r)
      dmc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = dmc_pkg::ST_TOP;
        end
      end

      dmc_pkg::ST_TOP: begin
        if (item_r.op == dmc_pkg::OP_START) begin
          sx_nxt    = item_r.start_x;
          sy_nxt    = item_r.start_y;
          state_nxt = dmc_pkg::ST_MOD;
        end else if (depth_r == '0) begin
          res_nxt.event_res = dmc_pkg::EV_IGNORED;
          res_nxt.cell_x    = '0;
          res_nxt.cell_y    = '0;
          res_nxt.wall_dir  = '0;
          state_nxt         = dmc_pkg::ST_EMIT;
        end else begin
          frame_nxt = stack_rd_data;
          dirs_nxt  = dmc_pkg::perm_dirs(avail, stack_rd_data.pick);
          cnt_nxt   = dmc_pkg::mask_count(avail);
          idx_nxt   = stack_rd_data.next;
          state_nxt = dmc_pkg::ST_SCAN;
        end
      end

      dmc_pkg::ST_MOD: begin
        if (sx_big) sx_nxt = dmc_pkg::COORD_W'(dmc_pkg::SIZE_W'(sx_r) - n_eff);
        if (sy_big) sy_nxt = dmc_pkg::COORD_W'(dmc_pkg::SIZE_W'(sy_r) - n_eff);
        if (!sx_big && !sy_big) begin
          if (epoch_r == '1) begin
            clr_cnt_nxt = '0;
            clr_ret_nxt = dmc_pkg::ST_START;
            state_nxt   = dmc_pkg::ST_CLEAR;
          end else begin
            state_nxt = dmc_pkg::ST_START;
          end
        end
      end

      dmc_pkg::ST_START: begin
        epoch_nxt             = epoch_r + 1'b1;
        maze_wr.en            = 1'b1;
        maze_wr.addr          = {sy_r, sx_r};
        maze_wr.data.epoch    = epoch_r + 1'b1;
        maze_wr.data.walls    = 4'hF & ~dmc_pkg::dir_bit(item_r.start_dir);
        stack_wr.en           = 1'b1;
        stack_wr.addr         = '0;
        stack_wr.data.x       = sx_r;
        stack_wr.data.y       = sy_r;
        stack_wr.data.from    = item_r.start_dir;
        stack_wr.data.pick    = item_r.order_pick;
        stack_wr.data.next    = '0;
        depth_nxt             = dmc_pkg::DEPTH_W'(1);
        res_nxt.event_res     = dmc_pkg::EV_ENTRANCE;
        res_nxt.cell_x        = sx_r;
        res_nxt.cell_y        = sy_r;
        res_nxt.wall_dir      = item_r.start_dir;
        state_nxt             = dmc_pkg::ST_EMIT;
      end

      dmc_pkg::ST_SCAN: begin
        if (idx_r >= cnt_r || depth_r == dmc_pkg::DEPTH_W'(dmc_pkg::CELLS)) begin
          depth_nxt         = depth_r - 1'b1;
          res_nxt.event_res = (depth_r == dmc_pkg::DEPTH_W'(1)) ? dmc_pkg::EV_FINISH
                                                               : dmc_pkg::EV_BACKTRACK;
          res_nxt.cell_x    = frame_r.x;
          res_nxt.cell_y    = frame_r.y;
          res_nxt.wall_dir  = '0;
          state_nxt         = dmc_pkg::ST_EMIT;
        end else if (d_sel == frame_r.from) begin
          idx_nxt = idx_r + 3'd1;
        end else begin
          maze_rd_addr = {ny_c, nx_c};
          nx_nxt       = nx_c;
          ny_nxt       = ny_c;
          dir_nxt      = d_sel;
          state_nxt    = dmc_pkg::ST_NCHK;
        end
      end

      dmc_pkg::ST_NCHK: begin
        if (hit) begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = dmc_pkg::ST_SCAN;
        end else begin
          maze_wr.en         = 1'b1;
          maze_wr.addr       = {ny_r, nx_r};
          maze_wr.data.epoch = epoch_r;
          maze_wr.data.walls = walls_eff & ~dmc_pkg::dir_bit(dir_r ^ 2'b01);
          maze_rd_addr       = {frame_r.y, frame_r.x};
          state_nxt          = dmc_pkg::ST_CUR;
        end
      end

      dmc_pkg::ST_CUR: begin
        maze_wr.en         = 1'b1;
        maze_wr.addr       = {frame_r.y, frame_r.x};
        maze_wr.data.epoch = epoch_r;
        maze_wr.data.walls = walls_eff & ~dmc_pkg::dir_bit(dir_r);
        stack_wr.en        = 1'b1;
        stack_wr.addr      = dmc_pkg::ADDR_W'(depth_r - 1'b1);
        stack_wr.data      = top_frame;
        state_nxt          = dmc_pkg::ST_PUSH;
      end

      dmc_pkg::ST_PUSH: begin
        stack_wr.en       = 1'b1;
        stack_wr.addr     = depth_r[dmc_pkg::ADDR_W-1:0];
        stack_wr.data     = push_frame;
        depth_nxt         = depth_r + 1'b1;
        res_nxt.event_res = dmc_pkg::EV_CARVE;
        res_nxt.cell_x    = frame_r.x;
        res_nxt.cell_y    = frame_r.y;
        res_nxt.wall_dir  = dir_r;
        state_nxt         = dmc_pkg::ST_EMIT;
      end

      dmc_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = dmc_pkg::ST_IDLE;
        end
      end

      dmc_pkg::ST_CLEAR: begin
        maze_wr.en         = 1'b1;
        maze_wr.addr       = clr_cnt_r;
        maze_wr.data.epoch = '0;
        maze_wr.data.walls = 4'hF;
        clr_cnt_nxt        = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          epoch_nxt = '0;
          state_nxt = clr_ret_r;
        end
      end

      default: begin
        state_nxt = dmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmc_pkg::ST_CLEAR;
      clr_ret_r   <= dmc_pkg::ST_IDLE;
      clr_cnt_r   <= '0;
      depth_r     <= '0;
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ret_r   <= clr_ret_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      depth_r     <= depth_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    res_r      <= res_nxt;
    item_r     <= item_nxt;
    frame_r    <= frame_nxt;
    dirs_r     <= dirs_nxt;
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    dir_r      <= dir_nxt;
  end

endmodule
